/* sv/lre_pkg.sv */
// Package with shared types, parser tables and codes for the expression evaluator.
package lre_pkg;

   localparam int StackDepth = 64;
   localparam int SpW = $clog2(StackDepth);

   localparam logic [2:0] TOK_NUM = 3'd0;
   localparam logic [2:0] TOK_PLUS = 3'd1;
   localparam logic [2:0] TOK_STAR = 3'd2;
   localparam logic [2:0] TOK_LPAR = 3'd3;
   localparam logic [2:0] TOK_RPAR = 3'd4;
   localparam logic [2:0] TOK_END = 3'd5;

   localparam logic [1:0] STAT_ACCEPT = 2'd0;
   localparam logic [1:0] STAT_SYNTAX = 2'd1;
   localparam logic [1:0] STAT_OVERFLOW = 2'd2;

   localparam logic [1:0] ACT_ERROR = 2'd0;
   localparam logic [1:0] ACT_SHIFT = 2'd1;
   localparam logic [1:0] ACT_REDUCE = 2'd2;
   localparam logic [1:0] ACT_ACCEPT = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] arg;
   } action_type;

   // Datapath commands from the controller.
   typedef struct packed {
      logic restart;
      logic load_top;
      logic shift;
      logic rd_base;
      logic reduce;
      logic [2:0] rule;
   } dp_cmd_type;

   typedef struct packed {
      logic [3:0] top_state;
      logic [SpW-1:0] sp;
      logic [32:0] top_value;
   } dp_status_type;

   function automatic action_type action_lookup(input logic [3:0] st, input logic [2:0] tk);
      action_type a;
      a = '{ACT_ERROR, 4'd0};
      unique case (st)
         4'd0, 4'd4, 4'd6, 4'd7: begin
            if (tk == TOK_NUM) a = '{ACT_SHIFT, 4'd5};
            else if (tk == TOK_LPAR) a = '{ACT_SHIFT, 4'd4};
         end
         4'd1: begin
            if (tk == TOK_PLUS) a = '{ACT_SHIFT, 4'd6};
            else if (tk == TOK_END) a = '{ACT_ACCEPT, 4'd0};
         end
         4'd2: begin
            if (tk == TOK_STAR) a = '{ACT_SHIFT, 4'd7};
            else if (tk == TOK_PLUS || tk == TOK_RPAR || tk == TOK_END)
               a = '{ACT_REDUCE, 4'd2};
         end
         4'd9: begin
            if (tk == TOK_STAR) a = '{ACT_SHIFT, 4'd7};
            else if (tk == TOK_PLUS || tk == TOK_RPAR || tk == TOK_END)
               a = '{ACT_REDUCE, 4'd1};
         end
         4'd3, 4'd5, 4'd10, 4'd11: begin
            if (tk == TOK_PLUS || tk == TOK_STAR || tk == TOK_RPAR || tk == TOK_END) begin
               a.kind = ACT_REDUCE;
               a.arg = (st == 4'd3) ? 4'd4 : (st == 4'd5) ? 4'd6 :
                       (st == 4'd10) ? 4'd3 : 4'd5;
            end
         end
         4'd8: begin
            if (tk == TOK_PLUS) a = '{ACT_SHIFT, 4'd6};
            else if (tk == TOK_RPAR) a = '{ACT_SHIFT, 4'd11};
         end
         default: a = '{ACT_ERROR, 4'd0};
      endcase
      return a;
   endfunction

   function automatic logic [1:0] rule_len(input logic [2:0] r);
      return (r == 3'd1 || r == 3'd3 || r == 3'd5) ? 2'd3 : 2'd1;
   endfunction

   function automatic logic [3:0] goto_lookup(input logic [3:0] st, input logic [2:0] r);
      logic [3:0] g;
      g = 4'd0;
      if (r == 3'd1 || r == 3'd2) g = (st == 4'd0) ? 4'd1 : (st == 4'd4) ? 4'd8 : 4'd0;
      else if (r == 3'd3 || r == 3'd4)
         g = (st == 4'd0 || st == 4'd4) ? 4'd2 : (st == 4'd6) ? 4'd9 : 4'd0;
      else g = (st == 4'd0 || st == 4'd4 || st == 4'd6) ? 4'd3 : (st == 4'd7) ? 4'd10 : 4'd0;
      return g;
   endfunction

endpackage

/* sv/lre_ram.sv */
// Generic RAM with one write port and one registered read port.
module lre_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

/* sv/lre_datapath.sv */
// Stacks, stack pointer and arithmetic unit of the expression evaluator.
module lre_datapath import lre_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   input  logic [3:0]           shift_state,
   input  logic [32:0]          shift_value,
   output dp_status_type        status
);
   logic [SpW-1:0] sp_ff, sp_in, base;
   logic [3:0] top_state_ff;
   logic [32:0] top_value_ff;
   logic [32:0] left_ff;
   logic [3:0] below_ff;
   logic s_we, v_we;
   logic [SpW-1:0] s_waddr, v_waddr, raddr;
   logic [3:0] s_wdata, s_rdata;
   logic [32:0] v_wdata, v_rdata, comb;
   logic [1:0] len;

   assign len = rule_len(cmd.rule);
   assign base = sp_ff - SpW'(len);

   // During the operand reads the state stack is held at the entry below the handle.
   always_comb begin
      raddr = sp_ff;
      if (cmd.rd_base) raddr = base;
   end

   lre_ram #(.Width(4), .Depth(StackDepth)) u_sstk (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr(raddr), .rd_data(s_rdata));
   lre_ram #(.Width(33), .Depth(StackDepth)) u_vstk (
      .clock(clock), .wr_en(v_we), .wr_addr(v_waddr), .wr_data(v_wdata),
      .rd_addr(cmd.rd_base ? base + ((cmd.rule == 3'd5) ? SpW'(2) : SpW'(1)) : sp_ff),
      .rd_data(v_rdata));

   // Combine the saved left operand with the right operand sitting at the top.
   lre_alu u_alu (
      .clock(clock), .a(left_ff), .b(top_value_ff), .is_mul(cmd.rule == 3'd3),
      .y(comb));

   always_comb begin
      s_we = 1'b0; v_we = 1'b0;
      s_waddr = sp_ff; v_waddr = sp_ff;
      s_wdata = 4'd0; v_wdata = '0;
      sp_in = sp_ff;
      // Reset also writes state 0 into the bottom entry.
      if (reset || cmd.restart) begin
         sp_in = '0; s_we = 1'b1; v_we = 1'b1; s_waddr = '0; v_waddr = '0;
      end else if (cmd.shift) begin
         sp_in = sp_ff + SpW'(1);
         s_we = 1'b1; v_we = 1'b1; s_waddr = sp_in; v_waddr = sp_in;
         s_wdata = shift_state; v_wdata = shift_value;
      end else if (cmd.reduce) begin
         sp_in = base + SpW'(1);
         s_we = 1'b1; v_we = 1'b1; s_waddr = sp_in; v_waddr = sp_in;
         s_wdata = goto_lookup(below_ff, cmd.rule);
         v_wdata = (cmd.rule == 3'd1 || cmd.rule == 3'd3) ? comb : left_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0; top_state_ff <= 4'd0; top_value_ff <= '0;
      end else begin
         sp_ff <= sp_in;
         if (cmd.restart) begin
            top_state_ff <= 4'd0; top_value_ff <= '0;
         end else if (cmd.shift) begin
            top_state_ff <= shift_state; top_value_ff <= shift_value;
         end else if (cmd.reduce) begin
            top_state_ff <= s_wdata; top_value_ff <= v_wdata;
         end else if (cmd.load_top) begin
            top_state_ff <= s_rdata; top_value_ff <= v_rdata;
         end
      end
      if (cmd.rd_base) begin
         left_ff <= v_rdata;
         below_ff <= s_rdata;
      end
   end

   assign status.top_state = top_state_ff;
   assign status.sp = sp_ff;
   assign status.top_value = top_value_ff;
endmodule

/* sv/lre_alu.sv */
// Integer (wrapping) and Q16.16 add and multiply; mixed operands are promoted and real results saturate.
module lre_alu import lre_pkg::*; (
   input  logic        clock,
   input  logic [32:0] a,
   input  logic [32:0] b,
   input  logic        is_mul,
   output logic [32:0] y
);
   logic ra, rb;
   logic signed [63:0] prod_ff, sum_ff;
   logic mode_mul_ff, both_real_ff, any_real_ff;
   logic signed [63:0] q, v;
   logic [31:0] sat;

   assign ra = a[32];
   assign rb = b[32];

   always_ff @(posedge clock) begin
      prod_ff <= 64'(signed'(a[31:0])) * 64'(signed'(b[31:0]));
      sum_ff <= (ra ? 64'(signed'(a[31:0])) : (ra | rb ? 64'(signed'(a[31:0])) <<< 16 :
                 64'(signed'(a[31:0])))) +
                (rb ? 64'(signed'(b[31:0])) : (ra | rb ? 64'(signed'(b[31:0])) <<< 16 :
                 64'(signed'(b[31:0]))));
      mode_mul_ff <= is_mul;
      both_real_ff <= ra & rb;
      any_real_ff <= ra | rb;
   end

   always_comb begin
      q = (prod_ff + 64'sd32768) >>> 16;
      v = mode_mul_ff ? (both_real_ff ? q : prod_ff) : sum_ff;
      if (v > 64'sd2147483647) sat = 32'h7fffffff;
      else if (v < -64'sd2147483648) sat = 32'h80000000;
      else sat = v[31:0];
      if (!any_real_ff) y = {1'b0, mode_mul_ff ? prod_ff[31:0] : sum_ff[31:0]};
      else y = {1'b1, sat};
   end
endmodule

/* sv/lre_ctrl.sv */
// Controller state machine: action lookup, reduce sequencing and result handshake.
module lre_ctrl import lre_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [2:0]    req_token_kind,
   input  logic          req_number_is_real,
   input  logic [31:0]   req_number_value,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   output logic          rsp_result_is_real,
   output logic [31:0]   rsp_result_value,
   output dp_cmd_type    cmd,
   output logic [3:0]    shift_state,
   output logic [32:0]   shift_value,
   input  dp_status_type status
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_RD0 = 3'd2;
   localparam logic [2:0] S_RD1 = 3'd3;
   localparam logic [2:0] S_ALU = 3'd4;
   localparam logic [2:0] S_WB = 3'd5;
   localparam logic [2:0] S_RELOAD = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] tok_ff;
   logic [32:0] num_ff;
   logic [2:0] rule_ff, rule_in;
   logic [1:0] alu_cnt_ff, alu_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [32:0] rsp_val_ff, rsp_val_in;
   action_type act;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign act = action_lookup(status.top_state, tok_ff);
   assign req_stall = (state_ff != S_IDLE);
   assign shift_state = act.arg;
   assign shift_value = (tok_ff == TOK_NUM) ? num_ff : 33'd0;

   always_comb begin
      state_in = state_ff; rule_in = rule_ff; alu_cnt_in = alu_cnt_ff;
      cmd = '0; cmd.rule = rule_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff; rsp_val_in = rsp_val_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_DECIDE;
         S_DECIDE: begin
            if (tok_ff > TOK_END || act.kind == ACT_ERROR ||
                (act.kind == ACT_SHIFT && status.sp == SpW'(StackDepth - 1)) ||
                act.kind == ACT_ACCEPT) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1; cmd.restart = 1'b1; state_in = S_IDLE;
                  rsp_val_in = '0;
                  if (tok_ff > TOK_END || act.kind == ACT_ERROR) rsp_status_in = STAT_SYNTAX;
                  else if (act.kind == ACT_SHIFT) rsp_status_in = STAT_OVERFLOW;
                  else begin
                     rsp_status_in = STAT_ACCEPT; rsp_val_in = status.top_value;
                  end
               end
            end else if (act.kind == ACT_SHIFT) begin
               cmd.shift = 1'b1; state_in = S_IDLE;
            end else begin
               rule_in = act.arg[2:0]; cmd.rule = act.arg[2:0];
               if (rule_len(act.arg[2:0]) == 2'd3) begin
                  cmd.rd_base = 1'b1; state_in = S_RD0;
               end else begin
                  cmd.rd_base = 1'b1; state_in = S_RD1;
               end
            end
         end
         S_RD0: begin cmd.rd_base = 1'b1; state_in = S_RD1; end
         S_RD1: begin cmd.rd_base = 1'b1; alu_cnt_in = 2'd0; state_in = S_ALU; end
         S_ALU: begin
            alu_cnt_in = alu_cnt_ff + 2'd1;
            if (alu_cnt_ff == 2'd1) state_in = S_WB;
         end
         S_WB: begin cmd.reduce = 1'b1; state_in = S_DECIDE; end
         S_RELOAD: begin cmd.load_top = 1'b1; state_in = S_DECIDE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid_ff <= 1'b0; rule_ff <= 3'd0; alu_cnt_ff <= 2'd0;
      end else begin
         state_ff <= state_in; rsp_valid_ff <= rsp_valid_in;
         rule_ff <= rule_in; alu_cnt_ff <= alu_cnt_in;
      end
      rsp_status_ff <= rsp_status_in; rsp_val_ff <= rsp_val_in;
      if (state_ff == S_IDLE && req_valid) begin
         tok_ff <= req_token_kind; num_ff <= {req_number_is_real, req_number_value};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_result_is_real = rsp_val_ff[32];
   assign rsp_result_value = rsp_val_ff[31:0];
endmodule

/* sv/lr_expression_evaluator.sv */
// Top level of the SLR(1) arithmetic expression parser and evaluator.
// One token word is taken per request; a token that shifts is taken and then
// decided, and each reduction before it adds operand reads from the
// registered-read stack RAMs, the registered ALU and a write-back before the
// next decision; req_stall holds further tokens until the token is done. Accept,
// syntax error or overflow produces one response word and restarts the parser,
// waiting while the response side stalls; reset writes state 0 into the bottom
// stack entry and the stacks need no clearing pass.
module lr_expression_evaluator import lre_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_token_kind,
   input  logic        req_number_is_real,
   input  logic signed [31:0] req_number_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_result_is_real,
   output logic signed [31:0] rsp_result_value
);
   dp_cmd_type cmd;
   dp_status_type status;
   logic [3:0] shift_state;
   logic [32:0] shift_value;

   lre_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_token_kind(req_token_kind), .req_number_is_real(req_number_is_real),
      .req_number_value(req_number_value), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_result_is_real(rsp_result_is_real),
      .rsp_result_value(rsp_result_value), .cmd(cmd), .shift_state(shift_state),
      .shift_value(shift_value), .status(status));

   lre_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .shift_state(shift_state),
      .shift_value(shift_value), .status(status));

   // Errors never carry a value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_ACCEPT |-> rsp_result_value == 32'd0)
      else $error("error response carries a value");

   // A restart empties the stack.
   assert property (@(posedge clock) disable iff (reset)
      cmd.restart |=> status.sp == '0)
      else $error("stack not emptied on restart");

   // Never shift and reduce together.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.shift && cmd.reduce))
      else $error("conflicting stack commands");
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the SLR(1) expression parser and evaluator.
module tb_top;
   import lre_pkg::*;

   localparam int AcceptCode = 999;
   localparam int Depth = 64;

   typedef struct {
      logic [2:0]  kind;
      logic        is_real;
      logic [31:0] value;
   } token_word_type;

   typedef struct {
      logic [1:0]  status;
      logic        is_real;
      logic [31:0] value;
   } result_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_token_kind = '0;
   logic req_number_is_real = 1'b0;
   logic signed [31:0] req_number_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic rsp_result_is_real;
   logic signed [31:0] rsp_result_value;

   token_word_type  token_queue[$];
   result_word_type expected_results[$];

   // Shadow copy of the parser stacks.
   logic [3:0]  shadow_states[Depth];
   logic [32:0] shadow_values[Depth];
   int          shadow_top;

   int error_count = 0;
   int cycle_count = 0;
   int tokens_taken = 0;
   int n_accept = 0, n_syntax = 0, n_overflow = 0;
   int hold_left = 0;
   bit stimulus_done = 0;

   lr_expression_evaluator uut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Idling is switched off in this window so the block runs back to back.
   function automatic bit quiet_window();
      return cycle_count > 2000 && cycle_count < 4000;
   endfunction

   function automatic int parse_action(int st, int k);
      case (st)
         0, 4, 6, 7: return (k == TOK_NUM) ? 5 : (k == TOK_LPAR) ? 4 : 0;
         1: return (k == TOK_PLUS) ? 6 : (k == TOK_END) ? AcceptCode : 0;
         2: return (k == TOK_STAR) ? 7 : (k == TOK_NUM || k == TOK_LPAR) ? 0 : -2;
         9: return (k == TOK_STAR) ? 7 : (k == TOK_NUM || k == TOK_LPAR) ? 0 : -1;
         3: return (k == TOK_NUM || k == TOK_LPAR) ? 0 : -4;
         5: return (k == TOK_NUM || k == TOK_LPAR) ? 0 : -6;
         10: return (k == TOK_NUM || k == TOK_LPAR) ? 0 : -3;
         11: return (k == TOK_NUM || k == TOK_LPAR) ? 0 : -5;
         8: return (k == TOK_PLUS) ? 6 : (k == TOK_RPAR) ? 11 : 0;
         default: return 0;
      endcase
   endfunction

   // Rules 1-2 yield an expression, 3-4 a term, 5-6 a factor.
   function automatic logic [3:0] goto_state(logic [3:0] st, int rule);
      if (rule <= 2) return (st == 0) ? 4'd1 : (st == 4) ? 4'd8 : 4'd0;
      if (rule <= 4) return (st == 0 || st == 4) ? 4'd2 : (st == 6) ? 4'd9 : 4'd0;
      return (st == 0 || st == 4 || st == 6) ? 4'd3 : (st == 7) ? 4'd10 : 4'd0;
   endfunction

   function automatic logic [32:0] saturate_real(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return {1'b1, v[31:0]};
   endfunction

   function automatic logic [32:0] combine_values(logic [32:0] a, logic [32:0] b, bit mul);
      longint x, y, p;
      x = longint'($signed(a[31:0]));
      y = longint'($signed(b[31:0]));
      if (!a[32] && !b[32])
         return {1'b0, mul ? a[31:0] * b[31:0] : a[31:0] + b[31:0]};
      if (!mul) begin
         if (!a[32]) x = x * 65536;
         if (!b[32]) y = y * 65536;
         return saturate_real(x + y);
      end
      if (a[32] && b[32]) begin
         p = x * y + 32768;
         return saturate_real(p >>> 16);
      end
      return saturate_real(x * y);
   endfunction

   function automatic void post_result(logic [1:0] status, logic [32:0] entry);
      result_word_type r;
      r.status = status;
      r.is_real = (status == STAT_ACCEPT) ? entry[32] : 1'b0;
      r.value = (status == STAT_ACCEPT) ? entry[31:0] : 32'd0;
      expected_results.push_back(r);
      shadow_top = 0;
      shadow_states[0] = 4'd0;
      shadow_values[0] = 33'd0;
   endfunction

   function automatic void evaluate_token(token_word_type t);
      int act, rule, len, base;
      logic [32:0] v;
      tokens_taken++;
      if (t.kind > TOK_END) begin
         post_result(STAT_SYNTAX, 33'd0);
         return;
      end
      for (int guard = 0; guard < 4 * Depth + 8; guard++) begin
         act = parse_action(shadow_states[shadow_top], t.kind);
         if (act == AcceptCode) begin
            post_result(STAT_ACCEPT, shadow_values[shadow_top]);
            return;
         end
         if (act > 0) begin
            if (shadow_top + 1 >= Depth) begin
               post_result(STAT_OVERFLOW, 33'd0);
               return;
            end
            shadow_top++;
            shadow_states[shadow_top] = act[3:0];
            shadow_values[shadow_top] = (t.kind == TOK_NUM) ? {t.is_real, t.value} : 33'd0;
            return;
         end
         if (act == 0) begin
            post_result(STAT_SYNTAX, 33'd0);
            return;
         end
         rule = -act;
         len = (rule % 2 == 1) ? 3 : 1;
         if (shadow_top < len) begin
            post_result(STAT_SYNTAX, 33'd0);
            return;
         end
         base = shadow_top - len;
         if (rule == 1) v = combine_values(shadow_values[base+1], shadow_values[base+3], 0);
         else if (rule == 3) v = combine_values(shadow_values[base+1], shadow_values[base+3], 1);
         else if (rule == 5) v = shadow_values[base+2];
         else v = shadow_values[base+1];
         shadow_states[base+1] = goto_state(shadow_states[base], rule);
         shadow_values[base+1] = v;
         shadow_top = base + 1;
      end
      post_result(STAT_SYNTAX, 33'd0);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   // Driver: the word on the port is taken at this edge when valid and not stalled.
   always @(posedge clock) begin
      token_word_type t;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            evaluate_token('{req_token_kind, req_number_is_real, req_number_value});
         if (token_queue.size() > 0 && (quiet_window() || $urandom_range(0, 99) >= 15)) begin
            t = token_queue.pop_front();
            req_valid <= 1'b1;
            req_token_kind <= t.kind;
            req_number_is_real <= t.is_real;
            req_number_value <= t.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall, with one long hold-off so the parser backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (cycle_count == 6000) begin
         hold_left <= 600;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet_window() && $urandom_range(0, 99) < 15;
      end
   end

   // Monitor.
   always @(posedge clock) begin
      result_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_status, 0);
         end else begin
            e = expected_results.pop_front();
            if (rsp_status != e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_result_is_real != e.is_real)
               report_mismatch("result_is_real", rsp_result_is_real, e.is_real);
            if (rsp_result_value != e.value)
               report_mismatch("result_value", rsp_result_value, e.value);
            case (e.status)
               STAT_ACCEPT: n_accept++;
               STAT_SYNTAX: n_syntax++;
               default: n_overflow++;
            endcase
         end
      end
   end

   function automatic void push_token(logic [2:0] kind, logic is_real = 1'b0,
                                      logic [31:0] value = 32'd0);
      token_word_type t;
      t.kind = kind;
      t.is_real = is_real;
      t.value = value;
      token_queue.push_back(t);
   endfunction

   function automatic logic [31:0] random_number(logic is_real);
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 20);
         1: return -$urandom_range(0, 20);
         2: return $urandom;
         3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return is_real ? $urandom_range(0, 32'h60000) - 32'h30000
                                 : $urandom_range(0, 2000) - 1000;
      endcase
   endfunction

   task automatic random_expression(int depth);
      int terms, factors;
      logic r;
      terms = $urandom_range(1, 3);
      for (int i = 0; i < terms; i++) begin
         if (i > 0) push_token(TOK_PLUS);
         factors = $urandom_range(1, 3);
         for (int j = 0; j < factors; j++) begin
            if (j > 0) push_token(TOK_STAR);
            if (depth < 4 && $urandom_range(0, 3) == 0) begin
               push_token(TOK_LPAR);
               random_expression(depth + 1);
               push_token(TOK_RPAR);
            end else begin
               r = 1'($urandom_range(0, 1));
               push_token(TOK_NUM, r, random_number(r));
            end
         end
      end
   endtask

   initial begin
      int pick, n;
      logic r;
      shadow_top = 0;
      shadow_states[0] = 4'd0;
      shadow_values[0] = 33'd0;
      // Directed: wrap, saturation, real rounding, bad codes and misplaced tokens.
      push_token(TOK_NUM, 1'b0, 32'h7fffffff);
      push_token(TOK_STAR);
      push_token(TOK_NUM, 1'b0, 32'd2);
      push_token(TOK_PLUS);
      push_token(TOK_NUM, 1'b1, 32'h80000000);
      push_token(TOK_END);
      push_token(TOK_LPAR);
      push_token(TOK_NUM, 1'b1, 32'h00018000);
      push_token(TOK_STAR);
      push_token(TOK_NUM, 1'b1, 32'hfffd8000);
      push_token(TOK_RPAR);
      push_token(TOK_STAR);
      push_token(TOK_NUM, 1'b0, 32'h00010000);
      push_token(TOK_END);
      push_token(3'd6);
      push_token(3'd7);
      push_token(TOK_RPAR);
      push_token(TOK_END);
      push_token(TOK_NUM, 1'b1, 32'h7fffffff);
      push_token(TOK_NUM, 1'b0, 32'd5);
      push_token(TOK_PLUS);
      push_token(TOK_END);
      while (token_queue.size() < 1650) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            random_expression(0);
            push_token(TOK_END);
         end else if (pick < 77) begin
            // Nesting near the stack depth; from 63 open brackets on it runs the stack out.
            n = $urandom_range(62, 66);
            for (int i = 0; i < n; i++) push_token(TOK_LPAR);
            push_token(TOK_NUM, 1'b0, $urandom);
            push_token(TOK_END);
         end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
               r = 1'($urandom_range(0, 1));
               push_token(3'($urandom_range(0, 7)), r, random_number(r));
            end
         end
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (token_queue.size() == 0);
      @(posedge clock);
      while (req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Run covered %0d tokens: %0d accepted, %0d syntax errors, %0d overflows.",
               tokens_taken, n_accept, n_syntax, n_overflow);
      if (error_count == 0 && expected_results.size() == 0)
         $display("lr_expression_evaluator verification clean");
      else
         $display("lr_expression_evaluator verification failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("lr_expression_evaluator verification failed");
      $finish;
   end

endmodule
